[rtl/ckc_pkg.sv]
// shared types and constants for the clock replacement keyed cache
package ckc_pkg;

	localparam int SLOTS_DEF      = 64;
	localparam int KEY_WIDTH_DEF  = 64;
	localparam int PAY_WIDTH_DEF  = 32;
	localparam int CMD_W          = 2;
	localparam int CAP_W          = 7;
	localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT = 2'd0,
		CMD_LOOKUP = 2'd1,
		CMD_ERASE  = 2'd2,
		CMD_CLEAR  = 2'd3
	} cmd_t;

	typedef struct packed {
		logic load;
		logic match;
		logic decide;
		logic update;
	} ctrl_cmd_t;

endpackage

[rtl/ckc_req_if.sv]
// request channel: command, key and payload
interface ckc_req_if #(
	parameter int KEY_WIDTH     = ckc_pkg::KEY_WIDTH_DEF,
	parameter int PAYLOAD_WIDTH = ckc_pkg::PAY_WIDTH_DEF
);
	logic                        valid;
	logic                        ready;
	logic [ckc_pkg::CMD_W-1:0]   cmd;
	logic [KEY_WIDTH-1:0]        key;
	logic [PAYLOAD_WIDTH-1:0]    payload;

	modport source (output valid, output cmd, output key, output payload, input ready);
	modport sink   (input valid, input cmd, input key, input payload, output ready);
endinterface

[rtl/ckc_rsp_if.sv]
// response channel: status, payload read, slot and occupancy
interface ckc_rsp_if #(
	parameter int SLOTS         = ckc_pkg::SLOTS_DEF,
	parameter int PAYLOAD_WIDTH = ckc_pkg::PAY_WIDTH_DEF
);
	localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W = $clog2(SLOTS + 1);

	logic                     valid;
	logic                     ready;
	logic                     ok;
	logic [PAYLOAD_WIDTH-1:0] data_out;
	logic [SW-1:0]            slot;
	logic [CNT_W-1:0]         entries;

	modport source (output valid, output ok, output data_out, output slot, output entries,
		input ready);
	modport sink   (input valid, input ok, input data_out, input slot, input entries,
		output ready);
endinterface

[rtl/ckc_cfg_if.sv]
// configuration write channel for the capacity register
interface ckc_cfg_if;
	logic                      valid;
	logic                      ready;
	logic [ckc_pkg::CAP_W-1:0] capacity;

	modport source (output valid, output capacity, input ready);
	modport sink   (input valid, input capacity, output ready);
endinterface

[rtl/ckc_ram.sv]
// generic single port ram with registered read
module ckc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[addr];
		end
	end
endmodule

[rtl/ckc_ctrl.sv]
// sequencer: accept, match, decide, update, respond
module ckc_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output ckc_pkg::ctrl_cmd_t cmd
);
	import ckc_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MATCH,
		ST_DECIDE,
		ST_UPDATE,
		ST_RESP
	} state_t;

	state_t state_q;
	logic   ready_q;
	logic   valid_q;

	assign req_ready  = ready_q;
	assign rsp_valid  = valid_q;
	assign cmd.load   = req_valid && ready_q;
	assign cmd.match  = (state_q == ST_MATCH);
	assign cmd.decide = (state_q == ST_DECIDE);
	assign cmd.update = (state_q == ST_UPDATE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ready_q <= 1'b1;
			valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (req_valid && ready_q) begin
						state_q <= ST_MATCH;
						ready_q <= 1'b0;
					end
				end
				ST_MATCH:  state_q <= ST_DECIDE;
				ST_DECIDE: state_q <= ST_UPDATE;
				ST_UPDATE: begin
					state_q <= ST_RESP;
					valid_q <= 1'b1;
				end
				ST_RESP: begin
					if (rsp_ready) begin
						state_q <= ST_IDLE;
						valid_q <= 1'b0;
						ready_q <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					ready_q <= 1'b1;
					valid_q <= 1'b0;
				end
			endcase
		end
	end
endmodule

[rtl/ckc_dp.sv]
// datapath: key cells, slot state, clock hand and payload store
module ckc_dp #(
	parameter int SLOTS         = ckc_pkg::SLOTS_DEF,
	parameter int KEY_WIDTH     = ckc_pkg::KEY_WIDTH_DEF,
	parameter int PAYLOAD_WIDTH = ckc_pkg::PAY_WIDTH_DEF,
	localparam int SW           = (SLOTS > 1) ? $clog2(SLOTS) : 1,
	localparam int CNT_W        = $clog2(SLOTS + 1)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  ckc_pkg::ctrl_cmd_t          cmd,
	input  logic [ckc_pkg::CMD_W-1:0]   req_cmd,
	input  logic [KEY_WIDTH-1:0]        req_key,
	input  logic [PAYLOAD_WIDTH-1:0]    req_payload,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [ckc_pkg::CAP_W-1:0]   cfg_capacity,
	output logic                        rsp_ok,
	output logic [PAYLOAD_WIDTH-1:0]    rsp_data_out,
	output logic [SW-1:0]               rsp_slot,
	output logic [CNT_W-1:0]            rsp_entries
);
	import ckc_pkg::*;

	localparam int CMPW = (CNT_W > CAP_W) ? CNT_W : CAP_W;
	localparam int RAW  = $clog2(SLOTS > 1 ? SLOTS : 2);

	cmd_t                     cmd_q;
	logic [KEY_WIDTH-1:0]     key_q;
	logic [PAYLOAD_WIDTH-1:0] pay_q;
	logic [CAP_W-1:0]         capacity_q;
	logic [KEY_WIDTH-1:0]     keys_q [SLOTS];
	logic [SLOTS-1:0]         occ_q;
	logic [SLOTS-1:0]         use_q;
	logic [CNT_W-1:0]         alloc_q;
	logic [CNT_W-1:0]         count_q;
	logic [SW-1:0]            hand_q;
	logic [SLOTS-1:0]         match_s1;

	// decision registers
	logic                     ok_q;
	logic [SW-1:0]            slot_q;
	logic                     fill_q;
	logic                     inc_count_q;
	logic                     inc_alloc_q;
	logic                     victim_q;
	logic [SLOTS-1:0]         clr_mask_q;
	logic [SW-1:0]            hand_next_q;

	logic [PAYLOAD_WIDTH-1:0] ram_rdata;

	function automatic logic [SW:0] first_set(input logic [SLOTS-1:0] v);
		logic [SW:0] res;
		res = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (v[i]) begin
				res = {1'b1, SW'(i)};
			end
		end
		return res;
	endfunction

	// decision logic
	logic [SLOTS-1:0] alloc_mask, hi_mask, lo_mask, cand, clr_mask;
	logic [SW:0]      hit, free, v1, v2;
	logic [SW-1:0]    hand_eff, victim, slot_d, hand_next;
	logic [CMPW-1:0]  cap_eff, alloc_x, victim_inc;
	logic             ok_d, fill_d, inc_count_d, inc_alloc_d, victim_d, all_set;

	assign alloc_x  = CMPW'(alloc_q);
	assign cap_eff  = (CMPW'(capacity_q) > CMPW'(SLOTS)) ? CMPW'(SLOTS) : CMPW'(capacity_q);
	assign hand_eff = (CMPW'(hand_q) >= alloc_x) ? '0 : hand_q;

	always_comb begin
		for (int i = 0; i < SLOTS; i++) begin
			alloc_mask[i] = CMPW'(i) < alloc_x;
			hi_mask[i]    = SW'(i) >= hand_eff;
		end
	end

	assign cand    = alloc_mask & ~use_q;
	assign hit     = first_set(match_s1);
	assign free    = first_set(alloc_mask & ~occ_q);
	assign v1      = first_set(cand & hi_mask);
	assign v2      = first_set(cand);
	assign all_set = !v2[SW];
	assign victim  = v1[SW] ? v1[SW-1:0] : (v2[SW] ? v2[SW-1:0] : hand_eff);

	always_comb begin
		for (int i = 0; i < SLOTS; i++) begin
			lo_mask[i] = SW'(i) < victim;
		end
	end

	// use bits the hand sweeps past on its way to the victim
	always_comb begin
		if (all_set) begin
			clr_mask = alloc_mask;
		end else if (victim >= hand_eff) begin
			clr_mask = hi_mask & lo_mask;
		end else begin
			clr_mask = hi_mask | lo_mask;
		end
	end

	assign victim_inc = CMPW'(victim) + CMPW'(1);
	assign hand_next  = (victim_inc >= alloc_x) ? '0 : SW'(victim_inc);

	always_comb begin
		ok_d        = 1'b0;
		slot_d      = '0;
		fill_d      = 1'b0;
		inc_count_d = 1'b0;
		inc_alloc_d = 1'b0;
		victim_d    = 1'b0;
		case (cmd_q)
			CMD_INSERT: begin
				if (pay_q != '0 && cap_eff != '0) begin
					ok_d   = 1'b1;
					fill_d = 1'b1;
					if (hit[SW]) begin
						slot_d = hit[SW-1:0];
					end else if (free[SW]) begin
						slot_d      = free[SW-1:0];
						inc_count_d = 1'b1;
					end else if (alloc_x < cap_eff) begin
						slot_d      = SW'(alloc_q);
						inc_count_d = 1'b1;
						inc_alloc_d = 1'b1;
					end else begin
						slot_d   = victim;
						victim_d = 1'b1;
					end
				end
			end
			CMD_LOOKUP, CMD_ERASE: begin
				ok_d   = hit[SW];
				slot_d = hit[SW] ? hit[SW-1:0] : '0;
			end
			CMD_CLEAR: ok_d = 1'b1;
			default: ok_d = 1'b0;
		endcase
	end

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (cfg_valid) begin
			capacity_q <= cfg_capacity;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q <= cmd_t'(req_cmd);
			key_q <= req_key;
			pay_q <= req_payload;
		end
		if (cmd.match) begin
			for (int i = 0; i < SLOTS; i++) begin
				match_s1[i] <= occ_q[i] && (keys_q[i] == key_q);
			end
		end
		if (cmd.decide) begin
			ok_q        <= ok_d;
			slot_q      <= slot_d;
			fill_q      <= fill_d;
			inc_count_q <= inc_count_d;
			inc_alloc_q <= inc_alloc_d;
			victim_q    <= victim_d;
			clr_mask_q  <= victim_d ? clr_mask : '0;
			hand_next_q <= hand_next;
		end
		if (cmd.update && fill_q) begin
			keys_q[slot_q] <= key_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q   <= '0;
			use_q   <= '0;
			alloc_q <= '0;
			count_q <= '0;
			hand_q  <= '0;
		end else if (cmd.update) begin
			if (cmd_q == CMD_CLEAR) begin
				occ_q   <= '0;
				use_q   <= '0;
				alloc_q <= '0;
				count_q <= '0;
				hand_q  <= '0;
			end else if (fill_q) begin
				occ_q[slot_q] <= 1'b1;
				use_q         <= (use_q & ~clr_mask_q) | (SLOTS'(1) << slot_q);
				if (inc_count_q) begin
					count_q <= count_q + CNT_W'(1);
				end
				if (inc_alloc_q) begin
					alloc_q <= alloc_q + CNT_W'(1);
				end
				if (victim_q) begin
					hand_q <= hand_next_q;
				end
			end else if (cmd_q == CMD_ERASE && ok_q) begin
				occ_q[slot_q] <= 1'b0;
				use_q[slot_q] <= 1'b0;
				count_q       <= count_q - CNT_W'(1);
			end
		end
	end

	ckc_ram #(
		.WIDTH (PAYLOAD_WIDTH),
		.DEPTH (SLOTS)
	) u_pay_ram (
		.clk   (clk),
		.we    (cmd.update && fill_q),
		.re    (cmd.update && cmd_q == CMD_LOOKUP && ok_q),
		.addr  (RAW'(slot_q)),
		.wdata (pay_q),
		.rdata (ram_rdata)
	);

	assign rsp_ok       = ok_q;
	assign rsp_slot     = slot_q;
	assign rsp_entries  = count_q;
	assign rsp_data_out = (cmd_q == CMD_LOOKUP && ok_q) ? ram_rdata : '0;
endmodule

[rtl/clock_replacement_keyed_cache_unit.sv]
// top level of the clock replacement keyed cache
//
//  channel | dir | handshake        | contents
//  req     | in  | valid / ready    | cmd, key, payload
//  rsp     | out | valid / ready    | ok, data_out, slot, entries
//  cfg     | in  | valid / ready    | capacity (always ready)
//
// a response turns valid after the item passes the match, decide and update states: key match over
// the key cells, a decision step with priority search and clock hand search, then
// an update step that also reads or writes the payload ram.
// one item is in flight at a time; req is ready again the cycle after rsp is taken.
// reset clears occupancy, use bits, counters and the hand at once; no sweep is needed.
// a stall on rsp holds the response and keeps req not ready.
module clock_replacement_keyed_cache_unit #(
	parameter int SLOTS         = ckc_pkg::SLOTS_DEF,
	parameter int KEY_WIDTH     = ckc_pkg::KEY_WIDTH_DEF,
	parameter int PAYLOAD_WIDTH = ckc_pkg::PAY_WIDTH_DEF
) (
	input logic      clk,
	input logic      arst_n,
	ckc_req_if.sink  req,
	ckc_rsp_if.source rsp,
	ckc_cfg_if.sink  cfg
);
	import ckc_pkg::*;

	ctrl_cmd_t cmd;

	ckc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.cmd       (cmd)
	);

	ckc_dp #(
		.SLOTS         (SLOTS),
		.KEY_WIDTH     (KEY_WIDTH),
		.PAYLOAD_WIDTH (PAYLOAD_WIDTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.req_cmd      (req.cmd),
		.req_key      (req.key),
		.req_payload  (req.payload),
		.cfg_valid    (cfg.valid),
		.cfg_ready    (cfg.ready),
		.cfg_capacity (cfg.capacity),
		.rsp_ok       (rsp.ok),
		.rsp_data_out (rsp.data_out),
		.rsp_slot     (rsp.slot),
		.rsp_entries  (rsp.entries)
	);
endmodule

[dv/ckc_tb_if.sv]
// testbench item types for requests and responses
package ckc_tb_pkg;
	import ckc_pkg::*;

	typedef struct packed {
		cmd_t        cmd;
		logic [63:0] key;
		logic [31:0] payload;
	} req_item_t;

	typedef struct packed {
		logic        ok;
		logic [31:0] data_out;
		logic [5:0]  slot;
		logic [6:0]  entries;
	} rsp_item_t;
endpackage

[dv/clock_replacement_keyed_cache_unit_tb.sv]
// testbench for the clock replacement keyed cache: directed and random items against a cache model
module clock_replacement_keyed_cache_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import ckc_pkg::*;
	import ckc_tb_pkg::*;

	localparam int WATCHDOG = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	ckc_req_if req ();
	ckc_rsp_if rsp ();
	ckc_cfg_if cfg ();

	clock_replacement_keyed_cache_unit i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req.sink),
		.rsp   (rsp.source),
		.cfg   (cfg.sink)
	);

	always #5 clk = ~clk;

	// cache model
	logic [63:0] m_key[64];
	logic [31:0] m_pay[64];
	logic        m_occ[64];
	logic        m_use[64];
	int unsigned m_alloc;
	int unsigned m_hand;
	int unsigned m_cap;

	req_item_t   pending_reqs[$];
	rsp_item_t   expected_rsps[$];
	logic [63:0] used_keys[$];
	int          fails = 0;
	int          idle_cycles = 0;
	int          burst_left = 0;
	int          gap_left = 0;
	bit          stim_done = 0;
	bit          hold_send = 0;

	function automatic void cache_clear_model();
		for (int i = 0; i < 64; i++) begin
			m_occ[i] = 0;
			m_use[i] = 0;
		end
		m_alloc = 0;
		m_hand = 0;
	endfunction

	function automatic int find_slot(logic [63:0] k);
		for (int i = 0; i < m_alloc && i < 64; i++)
			if (m_occ[i] && m_key[i] == k)
				return i;
		return -1;
	endfunction

	function automatic void step_hand();
		m_hand++;
		if (m_hand >= m_alloc)
			m_hand = 0;
	endfunction

	function automatic rsp_item_t predict_cache(req_item_t it);
		rsp_item_t r;
		int hit;
		int s;
		int unsigned cap_eff;
		int n;
		r = '0;
		cap_eff = (m_cap > 64) ? 64 : m_cap;
		hit = find_slot(it.key);
		case (it.cmd)
			CMD_INSERT: begin
				if (it.payload != 0 && cap_eff != 0) begin
					s = hit;
					if (s < 0)
						for (int i = 0; i < m_alloc && i < 64; i++)
							if (!m_occ[i]) begin
								s = i;
								break;
							end
					if (s < 0 && m_alloc < cap_eff) begin
						s = m_alloc;
						m_alloc++;
					end
					if (s < 0 && m_alloc > 0) begin
						// second chance scan
						for (int t = 0; t < 2 * m_alloc + 1; t++) begin
							if (m_hand >= m_alloc)
								m_hand = 0;
							if (!m_occ[m_hand] || !m_use[m_hand]) begin
								s = m_hand;
								step_hand();
								break;
							end
							m_use[m_hand] = 0;
							step_hand();
						end
					end
					if (s >= 0) begin
						m_key[s] = it.key;
						m_pay[s] = it.payload;
						m_occ[s] = 1;
						m_use[s] = 1;
						r.ok = 1;
						r.slot = s[5:0];
					end
				end
			end
			CMD_LOOKUP: begin
				if (hit >= 0) begin
					r.ok = 1;
					r.slot = hit[5:0];
					r.data_out = m_pay[hit];
				end
			end
			CMD_ERASE: begin
				if (hit >= 0) begin
					r.ok = 1;
					r.slot = hit[5:0];
					m_occ[hit] = 0;
					m_use[hit] = 0;
				end
			end
			default: begin
				cache_clear_model();
				r.ok = 1;
			end
		endcase
		n = 0;
		for (int i = 0; i < 64; i++)
			if (m_occ[i])
				n++;
		r.entries = n[6:0];
		return r;
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
			req.cmd <= CMD_LOOKUP;
			req.key <= '0;
			req.payload <= '0;
			burst_left <= 0;
			gap_left <= 0;
		end else begin
			if (req.valid && req.ready) begin
				expected_rsps = {expected_rsps, predict_cache(pending_reqs.pop_front())};
			end
			if (!req.valid || req.ready) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					req.valid <= 1'b0;
				end else if (pending_reqs.size() > 0 && !hold_send) begin
					req.valid <= 1'b1;
					req.cmd <= pending_reqs[0].cmd;
					req.key <= pending_reqs[0].key;
					req.payload <= pending_reqs[0].payload;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 30);
						gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
					end else
						burst_left <= burst_left - 1;
				end else
					req.valid <= 1'b0;
			end
		end
	end

	// monitor and receiver stall pattern
	int unsigned stall_phase = 0;
	always @(posedge clk or negedge arst_n) begin
		rsp_item_t got;
		rsp_item_t want;
		if (!arst_n) begin
			rsp.ready <= 1'b0;
			stall_phase <= 0;
		end else begin
			stall_phase <= stall_phase + 1;
			rsp.ready <= (stall_phase % 97 < 40) ? 1'b1 : ($urandom_range(0, 3) != 0);
			if (rsp.valid && rsp.ready) begin
				got = '{rsp.ok, rsp.data_out, rsp.slot, rsp.entries};
				if (expected_rsps.size() == 0) begin
					$error("unexpected response item");
					fails++;
				end else begin
					want = expected_rsps.pop_front();
					if (got.ok !== want.ok) begin
						$error("ok exp %0d got %0d", want.ok, got.ok);
						fails++;
					end
					if (got.data_out !== want.data_out) begin
						$error("data_out exp %h got %h", want.data_out, got.data_out);
						fails++;
					end
					if (got.slot !== want.slot) begin
						$error("slot exp %0d got %0d", want.slot, got.slot);
						fails++;
					end
					if (got.entries !== want.entries) begin
						$error("entries exp %0d got %0d", want.entries, got.entries);
						fails++;
					end
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("tb: failure");
			$finish;
		end
	end

	function automatic logic [63:0] pick_key();
		logic [63:0] k;
		if (used_keys.size() > 0 && $urandom_range(0, 3) != 0)
			return used_keys[$urandom_range(0, used_keys.size() - 1)];
		k = {$urandom, $urandom};
		used_keys = {used_keys, k};
		return k;
	endfunction

	task automatic queue_item(cmd_t c, logic [63:0] k, logic [31:0] p);
		req_item_t it;
		it = '{c, k, p};
		pending_reqs = {pending_reqs, it};
	endtask

	task automatic drain_and_settle();
		wait (pending_reqs.size() == 0 && !req.valid);
		wait (expected_rsps.size() == 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_capacity(int unsigned c);
		@(posedge clk);
		cfg.valid <= 1'b1;
		cfg.capacity <= c[6:0];
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		m_cap = c;
	endtask

	task automatic random_phase(int count, int key_pool);
		int r;
		logic [63:0] k;
		used_keys.delete();
		for (int i = 0; i < key_pool; i++) begin
			k = {$urandom, $urandom};
			used_keys = {used_keys, k};
		end
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			if (r < 50)
				queue_item(CMD_INSERT, pick_key(), ($urandom_range(0, 20) == 0) ? 32'd0 : $urandom);
			else if (r < 75)
				queue_item(CMD_LOOKUP, pick_key(), $urandom);
			else if (r < 97)
				queue_item(CMD_ERASE, pick_key(), $urandom);
			else
				queue_item(CMD_CLEAR, {$urandom, $urandom}, $urandom);
		end
	endtask

	initial begin
		cfg.valid = 1'b0;
		cfg.capacity = CAP_RESET;
		m_cap = 64;
		cache_clear_model();
		for (int i = 0; i < 64; i++) begin
			m_key[i] = '0;
			m_pay[i] = '0;
		end
		repeat (7) @(posedge clk);
		arst_n = 1'b1;

		// directed: extremes, every command, zero payload, misses
		queue_item(CMD_LOOKUP, 64'd0, 32'd0);
		queue_item(CMD_ERASE, '1, 32'd5);
		queue_item(CMD_INSERT, 64'd0, 32'd0);
		queue_item(CMD_INSERT, 64'd0, '1);
		queue_item(CMD_INSERT, '1, 32'd1);
		queue_item(CMD_INSERT, 64'h5555_aaaa_5555_aaaa, 32'haaaa_5555);
		queue_item(CMD_LOOKUP, '1, 32'd0);
		queue_item(CMD_LOOKUP, 64'd0, '1);
		queue_item(CMD_INSERT, '1, 32'h8000_0000);
		queue_item(CMD_LOOKUP, '1, 32'd0);
		queue_item(CMD_ERASE, 64'd0, 32'd0);
		queue_item(CMD_LOOKUP, 64'd0, 32'd0);
		queue_item(CMD_INSERT, 64'h1234, 32'd7);
		queue_item(CMD_CLEAR, 64'd0, 32'd0);
		queue_item(CMD_LOOKUP, '1, 32'd0);
		drain_and_settle();

		// zero capacity rejects inserts
		write_capacity(0);
		queue_item(CMD_INSERT, 64'd9, 32'd9);
		queue_item(CMD_LOOKUP, 64'd9, 32'd0);
		drain_and_settle();

		// small capacity: heavy replacement
		write_capacity(3);
		random_phase(200, 6);
		drain_and_settle();

		// lower capacity below the allocated count
		write_capacity(1);
		random_phase(100, 5);
		repeat (60) @(posedge clk);
		// sender holds until every response is back
		hold_send = 1;
		wait (expected_rsps.size() == 0 && !req.valid);
		repeat (3) @(posedge clk);
		hold_send = 0;
		drain_and_settle();

		// above the slot count acts as full size
		write_capacity(127);
		for (int i = 0; i < 70; i++)
			queue_item(CMD_INSERT, {$urandom, $urandom}, $urandom | 32'd1);
		random_phase(200, 80);
		drain_and_settle();

		write_capacity(64);
		random_phase(180, 70);
		drain_and_settle();

		write_capacity(17);
		random_phase(180, 30);
		drain_and_settle();

		stim_done = 1;
		repeat (20) @(posedge clk);
		if (fails == 0 && expected_rsps.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule
